@@ rtl/core/kfct_pkg.sv @@
// Shared constants, codes and interface types of the keyed flow counter table.
package kfct_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned TABLE_AW      = $clog2(TABLE_ENTRIES);
  localparam int unsigned KEY_W         = 32;
  localparam int unsigned LEN_W         = 16;
  localparam int unsigned CNT_W         = 64;
  localparam int unsigned KEY_WORD_W    = KEY_W + 1;
  localparam int unsigned CNT_WORD_W    = 2 * CNT_W;

  typedef enum logic [1:0] {
    OP_COUNT  = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STS_OK           = 2'd0,
    STS_KEY_CONFLICT = 2'd1,
    STS_FULL         = 2'd2,
    STS_NOT_COUNTED  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_UPDATE
  } state_e;

  // Key memory word: valid flag on top of the counter id.
  typedef struct packed {
    logic                  we;
    logic [TABLE_AW-1:0]   waddr;
    logic [KEY_WORD_W-1:0] wdata;
    logic                  re;
    logic [TABLE_AW-1:0]   raddr;
  } key_req_t;

  // Counter memory word: packet count above byte count.
  typedef struct packed {
    logic                  we;
    logic [TABLE_AW-1:0]   waddr;
    logic [CNT_WORD_W-1:0] wdata;
    logic                  re;
    logic [TABLE_AW-1:0]   raddr;
  } cnt_req_t;

  typedef struct packed {
    logic             valid;
    status_e          status;
    logic [CNT_W-1:0] packets;
    logic [CNT_W-1:0] bytes;
  } res_t;

endpackage

@@ rtl/core/kfct_ram.sv @@
// Simple dual-port synchronous RAM with a registered read port.
module kfct_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/kfct_ctrl.sv @@
// Sequencer of the counter table: clearing pass, key scan and counter update.
module kfct_ctrl import kfct_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            operation_i,
  input  logic [KEY_W-1:0]      counter_id_i,
  input  logic [LEN_W-1:0]      packet_length_i,
  input  logic                  require_existing_i,
  input  logic                  out_free_i,
  output key_req_t              key_req_o,
  input  logic [KEY_WORD_W-1:0] key_rdata_i,
  output cnt_req_t              cnt_req_o,
  input  logic [CNT_WORD_W-1:0] cnt_rdata_i,
  output res_t                  res_o
);

  localparam logic [TABLE_AW-1:0] LastAddr = TABLE_AW'(TABLE_ENTRIES - 1);

  state_e              state_q, state_d;
  logic [TABLE_AW-1:0] scan_addr_q;
  logic [TABLE_AW-1:0] cmp_addr_q;
  logic                rd_pend_q;
  logic                hit_q;
  logic                free_found_q;
  logic [TABLE_AW-1:0] hit_slot_q;
  logic [TABLE_AW-1:0] free_slot_q;
  logic [1:0]          op_q;
  logic [KEY_W-1:0]    key_q;
  logic [LEN_W-1:0]    len_q;

  logic             accept;
  logic             ent_match;
  logic             ent_empty;
  logic [CNT_W-1:0] pk_inc;
  logic [CNT_W-1:0] by_inc;
  logic [CNT_W-1:0] len_ext;

  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign ent_match = rd_pend_q && key_rdata_i[KEY_W] && (key_rdata_i[KEY_W-1:0] == key_q);
  assign ent_empty = rd_pend_q && !key_rdata_i[KEY_W];
  assign len_ext   = {{(CNT_W - LEN_W){1'b0}}, len_q};
  assign pk_inc    = cnt_rdata_i[CNT_WORD_W-1:CNT_W] + CNT_W'(1);
  assign by_inc    = cnt_rdata_i[CNT_W-1:0] + len_ext;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (scan_addr_q == LastAddr) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_addr_q == LastAddr) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_d = ST_DECIDE;
      ST_DECIDE:   state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      scan_addr_q  <= '0;
      rd_pend_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= (state_q == ST_SCAN);
      if (state_q == ST_CLEAR || state_q == ST_SCAN) begin
        scan_addr_q <= (scan_addr_q == LastAddr) ? '0 : scan_addr_q + TABLE_AW'(1);
      end
      if (accept) begin
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end else begin
        if (ent_match) begin
          hit_q <= 1'b1;
        end
        if (ent_empty) begin
          free_found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_addr_q <= scan_addr_q;
    if (accept) begin
      op_q  <= operation_i;
      key_q <= counter_id_i;
      len_q <= packet_length_i;
    end
    if (ent_match) begin
      hit_slot_q <= cmp_addr_q;
    end
    // The scan runs upward, so the first empty entry seen is the lowest one.
    if (ent_empty && !free_found_q) begin
      free_slot_q <= cmp_addr_q;
    end
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    key_req_o  = '0;
    cnt_req_o  = '0;
    res_o      = '0;
    unique case (state_q)
      ST_CLEAR: begin
        key_req_o.we    = 1'b1;
        key_req_o.waddr = scan_addr_q;
      end
      ST_SCAN: begin
        key_req_o.re    = 1'b1;
        key_req_o.raddr = scan_addr_q;
      end
      ST_DECIDE: begin
        cnt_req_o.re    = hit_q;
        cnt_req_o.raddr = hit_slot_q;
      end
      ST_UPDATE: begin
        if (out_free_i) begin
          res_o.valid = 1'b1;
          unique case (op_q)
            OP_COUNT: begin
              if (hit_q) begin
                cnt_req_o.we    = 1'b1;
                cnt_req_o.waddr = hit_slot_q;
                cnt_req_o.wdata = {pk_inc, by_inc};
                res_o.status    = STS_OK;
                res_o.packets   = pk_inc;
                res_o.bytes     = by_inc;
              end else if (require_existing_i) begin
                res_o.status = STS_NOT_COUNTED;
              end else if (free_found_q) begin
                key_req_o.we    = 1'b1;
                key_req_o.waddr = free_slot_q;
                key_req_o.wdata = {1'b1, key_q};
                cnt_req_o.we    = 1'b1;
                cnt_req_o.waddr = free_slot_q;
                cnt_req_o.wdata = {CNT_W'(1), len_ext};
                res_o.status    = STS_OK;
                res_o.packets   = CNT_W'(1);
                res_o.bytes     = len_ext;
              end else begin
                res_o.status = STS_FULL;
              end
            end
            OP_ADD: begin
              if (hit_q) begin
                res_o.status = STS_KEY_CONFLICT;
              end else if (free_found_q) begin
                key_req_o.we    = 1'b1;
                key_req_o.waddr = free_slot_q;
                key_req_o.wdata = {1'b1, key_q};
                cnt_req_o.we    = 1'b1;
                cnt_req_o.waddr = free_slot_q;
                res_o.status    = STS_OK;
              end else begin
                res_o.status = STS_FULL;
              end
            end
            OP_REMOVE: begin
              if (hit_q) begin
                key_req_o.we    = 1'b1;
                key_req_o.waddr = hit_slot_q;
                key_req_o.wdata = {1'b0, key_q};
                res_o.status    = STS_OK;
                res_o.packets   = cnt_rdata_i[CNT_WORD_W-1:CNT_W];
                res_o.bytes     = cnt_rdata_i[CNT_W-1:0];
              end else begin
                res_o.status = STS_KEY_CONFLICT;
              end
            end
            default: res_o.status = STS_NOT_COUNTED;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/keyed_flow_counter_table.sv @@
// Keyed flow counter table: an accepted beat passes the key scan, scan end, decide and
// update states and then the output register. The key memory is scanned one entry per
// cycle; input stays stalled until update is left, and update waits for a free output
// register, so a new beat is taken only once the last one is done. After reset a
// clearing pass marks every entry free; input is stalled during it, configuration
// writes are taken at any time. Reset sets require_q to 1 and empties the output register.
module keyed_flow_counter_table import kfct_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [1:0]       operation_i,
  input  logic [KEY_W-1:0] counter_id_i,
  input  logic [LEN_W-1:0] packet_length_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       status_o,
  output logic [CNT_W-1:0] packet_total_o,
  output logic [CNT_W-1:0] byte_total_o,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i
);

  // Configuration: when set, packets with unknown ids are dropped rather than
  // allocating a new entry.
  logic require_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      require_q <= 1'b1;
    end else if (cfg_we_i) begin
      require_q <= cfg_wdata_i;
    end
  end

  key_req_t              key_req;
  cnt_req_t              cnt_req;
  logic [KEY_WORD_W-1:0] key_rdata;
  logic [CNT_WORD_W-1:0] cnt_rdata;
  res_t                  res;
  logic                  out_free;

  // The key memory holds a valid flag with each id; the counter memory holds
  // the packet and byte counts of the same slot.
  kfct_ram #(
    .Width (KEY_WORD_W),
    .Depth (TABLE_ENTRIES)
  ) u_key_mem (
    .clk_i   (clk_i),
    .we_i    (key_req.we),
    .waddr_i (key_req.waddr),
    .wdata_i (key_req.wdata),
    .re_i    (key_req.re),
    .raddr_i (key_req.raddr),
    .rdata_o (key_rdata)
  );

  kfct_ram #(
    .Width (CNT_WORD_W),
    .Depth (TABLE_ENTRIES)
  ) u_cnt_mem (
    .clk_i   (clk_i),
    .we_i    (cnt_req.we),
    .waddr_i (cnt_req.waddr),
    .wdata_i (cnt_req.wdata),
    .re_i    (cnt_req.re),
    .raddr_i (cnt_req.raddr),
    .rdata_o (cnt_rdata)
  );

  kfct_ctrl u_ctrl (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .operation_i        (operation_i),
    .counter_id_i       (counter_id_i),
    .packet_length_i    (packet_length_i),
    .require_existing_i (require_q),
    .out_free_i         (out_free),
    .key_req_o          (key_req),
    .key_rdata_i        (key_rdata),
    .cnt_req_o          (cnt_req),
    .cnt_rdata_i        (cnt_rdata),
    .res_o              (res)
  );

  // Output register. It frees the input side: a new beat is taken and scanned
  // while a finished result still waits downstream. The sequencer only commits
  // an update once this register can take its result.
  logic             out_valid_q;
  status_e          status_q;
  logic [CNT_W-1:0] packet_q;
  logic [CNT_W-1:0] byte_q;

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      status_q <= res.status;
      packet_q <= res.packets;
      byte_q   <= res.bytes;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign packet_total_o = packet_q;
  assign byte_total_o   = byte_q;

`ifndef SYNTHESIS
  // A result is never committed over one that is still waiting downstream.
  a_res_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (!out_valid_q || !out_stall_i))
    else $error("result committed while output register is held");

  // After an accepted beat the block is busy with it in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  // Allocation writes the key and its counters into the same slot.
  a_same_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_req.we && cnt_req.we) |-> (key_req.waddr == cnt_req.waddr))
    else $error("key and counter writes target different slots");

  // Any failed beat reports zero totals.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != STS_OK)) |-> (packet_q == '0 && byte_q == '0))
    else $error("nonzero totals on a failed beat");
`endif

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for the keyed flow counter table.
`timescale 1ns / 1ps

module testbench;
  import kfct_pkg::*;

  // Operation code 3 has no meaning; the block must answer it as not counted.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned POOL_SIZE = 128;
  localparam int unsigned MAX_REPORTS = 10;

  // One predicted answer of the table.
  typedef struct {
    status_e          status;
    logic [CNT_W-1:0] packets;
    logic [CNT_W-1:0] bytes;
  } flow_answer_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [1:0]       operation_i;
  logic [KEY_W-1:0] counter_id_i;
  logic [LEN_W-1:0] packet_length_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [1:0]       status_o;
  logic [CNT_W-1:0] packet_total_o;
  logic [CNT_W-1:0] byte_total_o;
  logic             cfg_we_i;
  logic             cfg_wdata_i;

  keyed_flow_counter_table u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .counter_id_i    (counter_id_i),
    .packet_length_i (packet_length_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .packet_total_o  (packet_total_o),
    .byte_total_o    (byte_total_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  // 20 ns clock period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the counter table, kept in step with every accepted beat.
  logic             slot_used [TABLE_ENTRIES];
  logic [KEY_W-1:0] slot_key [TABLE_ENTRIES];
  logic [CNT_W-1:0] slot_packets [TABLE_ENTRIES];
  logic [CNT_W-1:0] slot_bytes [TABLE_ENTRIES];
  int               slots_in_use;
  logic             strict_lookup;

  // Answers still owed by the block, oldest first.
  flow_answer_t pending_answers[$];
  int           error_count;

  // Key pool shared by the random tests so that ids repeat and entries get hit.
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  // Sender pacing: bursts of back-to-back beats separated by random gaps.
  int burst_left;
  bit gaps_enabled;

  // Receiver stall pattern: the mode and its run length change on their own.
  int stall_mode;
  int stall_run;

  // Computes the answer of one beat and applies its effect to the shadow table.
  // A new entry always takes the lowest-numbered free slot.
  function automatic flow_answer_t predict_table_op(logic [1:0] op, logic [KEY_W-1:0] id,
                                                     logic [LEN_W-1:0] len);
    flow_answer_t ans;
    int hit;
    int free;
    hit  = -1;
    free = -1;
    ans.status  = STS_OK;
    ans.packets = '0;
    ans.bytes   = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (slot_used[i] && slot_key[i] == id) hit = i;
      if (!slot_used[i]) free = i;
    end
    case (op)
      OP_COUNT: begin
        if (hit < 0 && strict_lookup) begin
          ans.status = STS_NOT_COUNTED;
        end else if (hit < 0 && free < 0) begin
          ans.status = STS_FULL;
        end else begin
          // With lookup checking off, a miss opens a zeroed entry first.
          if (hit < 0) begin
            hit               = free;
            slot_used[hit]    = 1'b1;
            slot_key[hit]     = id;
            slot_packets[hit] = '0;
            slot_bytes[hit]   = '0;
            slots_in_use++;
          end
          slot_packets[hit] = slot_packets[hit] + CNT_W'(1);
          slot_bytes[hit]   = slot_bytes[hit] + CNT_W'(len);
          ans.packets       = slot_packets[hit];
          ans.bytes         = slot_bytes[hit];
        end
      end
      OP_ADD: begin
        if (hit >= 0) begin
          ans.status = STS_KEY_CONFLICT;
        end else if (free < 0) begin
          ans.status = STS_FULL;
        end else begin
          slot_used[free]    = 1'b1;
          slot_key[free]     = id;
          slot_packets[free] = '0;
          slot_bytes[free]   = '0;
          slots_in_use++;
        end
      end
      OP_REMOVE: begin
        if (hit < 0) begin
          ans.status = STS_KEY_CONFLICT;
        end else begin
          ans.packets    = slot_packets[hit];
          ans.bytes      = slot_bytes[hit];
          slot_used[hit] = 1'b0;
          slots_in_use--;
        end
      end
      default: begin
        ans.status = STS_NOT_COUNTED;
      end
    endcase
    return ans;
  endfunction

  // Drives one beat, holds it until the block takes it, then records the answer.
  // Valid is left high so that the next beat can follow without a gap.
  task automatic send_beat(logic [1:0] op, logic [KEY_W-1:0] id, logic [LEN_W-1:0] len);
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    counter_id_i    <= id;
    packet_length_i <= len;
    do @(posedge clk_i); while (in_stall_o);
    pending_answers.push_back(predict_table_op(op, id, len));
  endtask

  // Ends the current burst after its last beat and sits out a random gap.
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 15);
      gap = gaps_enabled ? $urandom_range(0, 90) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stops sending and waits until every owed answer has been taken.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Writes the lookup checking register while the block holds no work.
  task automatic set_strict_lookup(logic value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i      <= 1'b0;
    strict_lookup = value;
  endtask

  // Packet lengths lean on the two extremes now and then.
  function automatic logic [LEN_W-1:0] pick_length();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return LEN_W'($urandom);
  endfunction

  // One random beat: ids mostly from the first pool_span pool keys, with a few
  // fresh random ids and a little unused-opcode noise mixed in.
  task automatic send_random_beat(int pool_span, int count_pct, int add_pct);
    int               roll;
    logic [1:0]       op;
    logic [KEY_W-1:0] id;
    roll = $urandom_range(0, 99);
    if (roll < 2) op = OP_UNUSED;
    else if (roll < 2 + count_pct) op = OP_COUNT;
    else if (roll < 2 + count_pct + add_pct) op = OP_ADD;
    else op = OP_REMOVE;
    if ($urandom_range(0, 9) == 0) id = $urandom;
    else id = key_pool[$urandom_range(0, pool_span - 1)];
    send_beat(op, id, pick_length());
    pace_sender();
  endtask

  // The reset value of the register, every operation, the id and length
  // extremes, key conflicts, removes of absent ids and the unused opcode.
  task automatic test_directed_basics();
    gaps_enabled = 1'b0;
    send_beat(OP_COUNT, 32'h0000_0000, 16'h0010);
    send_beat(OP_REMOVE, 32'hFFFF_FFFF, 16'h0000);
    send_beat(OP_ADD, 32'h0000_0000, 16'hFFFF);
    send_beat(OP_ADD, 32'hFFFF_FFFF, 16'h0000);
    send_beat(OP_ADD, 32'h0000_0000, 16'h0000);
    send_beat(OP_COUNT, 32'h0000_0000, 16'h0000);
    send_beat(OP_COUNT, 32'h0000_0000, 16'hFFFF);
    send_beat(OP_COUNT, 32'hFFFF_FFFF, 16'h0001);
    send_beat(OP_COUNT, 32'h5A5A_A5A5, 16'hFFFF);
    send_beat(OP_REMOVE, 32'h0000_0000, 16'h0000);
    send_beat(OP_REMOVE, 32'h0000_0000, 16'h0000);
    send_beat(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    send_beat(OP_UNUSED, 32'h0000_0000, 16'h0000);
    send_beat(OP_COUNT, 32'hFFFF_FFFF, 16'hFFFF);
    send_beat(OP_ADD, 32'h0000_0000, 16'h1234);
    // Lookup checking off: a miss opens a new entry and counts into it.
    set_strict_lookup(1'b0);
    send_beat(OP_COUNT, 32'h8000_0000, 16'hFFFF);
    send_beat(OP_COUNT, 32'h8000_0000, 16'hFFFF);
    send_beat(OP_COUNT, 32'h7FFF_FFFF, 16'h0000);
    send_beat(OP_REMOVE, 32'h8000_0000, 16'h0000);
    send_beat(OP_REMOVE, 32'hFFFF_FFFF, 16'h0000);
    send_beat(OP_UNUSED, 32'h7FFF_FFFF, 16'h8000);
    set_strict_lookup(1'b1);
  endtask

  // Fills the table with fresh ids, then checks that adds and allocating
  // counts are refused while it is full, then removes entries until half are left.
  task automatic test_table_full();
    int slot;
    gaps_enabled = 1'b1;
    while (slots_in_use < TABLE_ENTRIES) begin
      send_beat(OP_ADD, $urandom, pick_length());
      pace_sender();
    end
    repeat (3) begin
      send_beat(OP_ADD, $urandom, pick_length());
      pace_sender();
    end
    send_beat(OP_COUNT, $urandom, pick_length());
    set_strict_lookup(1'b0);
    repeat (3) begin
      send_beat(OP_COUNT, $urandom, pick_length());
      pace_sender();
    end
    // Hits on stored ids still count while the table is full.
    repeat (20) begin
      slot = $urandom_range(0, TABLE_ENTRIES - 1);
      send_beat(OP_COUNT, slot_key[slot], pick_length());
      pace_sender();
    end
    while (slots_in_use > TABLE_ENTRIES / 2) begin
      slot = $urandom_range(0, TABLE_ENTRIES - 1);
      send_beat(OP_REMOVE, slot_key[slot], 16'h0000);
      pace_sender();
    end
    set_strict_lookup(1'b1);
  endtask

  // Long random mix with lookup checking on; the pool is larger than the
  // table so the table fills, overflows and frees entries many times.
  task automatic test_random_strict();
    gaps_enabled = 1'b1;
    repeat (170) send_random_beat(96, 40, 38);
    // Hold the sender until every owed answer is back, then carry on.
    wait_drained();
    gaps_enabled = 1'b0;
    repeat (80) send_random_beat(96, 40, 38);
    gaps_enabled = 1'b1;
    repeat (120) send_random_beat(96, 35, 40);
  endtask

  // Random mix with lookup checking off: count misses allocate entries.
  task automatic test_random_allocating();
    set_strict_lookup(1'b0);
    gaps_enabled = 1'b1;
    repeat (200) send_random_beat(POOL_SIZE, 60, 12);
    gaps_enabled = 1'b0;
    repeat (60) send_random_beat(POOL_SIZE, 60, 12);
    gaps_enabled = 1'b1;
    repeat (100) send_random_beat(POOL_SIZE, 55, 10);
  endtask

  // Small hot key set with heavy counting, flipping the register between
  // short phases so that both settings meet a busy table.
  task automatic test_random_hot_keys();
    gaps_enabled = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      set_strict_lookup(phase[0]);
      repeat (60) send_random_beat(16, 70, 15);
    end
    set_strict_lookup(1'b1);
  endtask

  // Receiver: free-running, stretches of random stalls, solid stall blocks.
  always @(posedge clk_i) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run  <= $urandom_range(20, 400);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= 1'($urandom_range(0, 1));
      default: out_stall_i <= stall_run[5];
    endcase
  end

  // Checks each accepted result beat against the oldest owed answer.
  always @(posedge clk_i) begin
    flow_answer_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("ERROR %0t: result beat with none owed: status %0d packets %0h bytes %0h",
                   $realtime, status_o, packet_total_o, byte_total_o);
        end
      end else begin
        want = pending_answers.pop_front();
        if (status_o !== want.status || packet_total_o !== want.packets ||
            byte_total_o !== want.bytes) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("ERROR %0t: status %0d/%0d packets %0h/%0h bytes %0h/%0h (exp/act)",
                     $realtime, want.status, status_o, want.packets, packet_total_o,
                     want.bytes, byte_total_o);
          end
        end
      end
    end
  end

  // Hard stop well past the slowest correct run.
  initial begin
    #25_000_000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    operation_i     = OP_COUNT;
    counter_id_i    = '0;
    packet_length_i = '0;
    out_stall_i     = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = 1'b0;
    stall_mode      = 0;
    stall_run       = 0;
    burst_left      = 0;
    gaps_enabled    = 1'b0;
    error_count     = 0;
    slots_in_use    = 0;
    strict_lookup   = 1'b1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      slot_used[i]    = 1'b0;
      slot_key[i]     = '0;
      slot_packets[i] = '0;
      slot_bytes[i]   = '0;
    end
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // The block runs a clearing pass after reset; it stalls input meanwhile.
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_basics();
    test_table_full();
    test_random_strict();
    test_random_allocating();
    test_random_hot_keys();

    // Let the last results drain, then watch for any stray beat.
    wait_drained();
    repeat (3 * TABLE_ENTRIES) @(posedge clk_i);
    if (error_count == 0 && pending_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/kfct_pkg.sv
rtl/core/kfct_ram.sv
rtl/core/kfct_ctrl.sv
rtl/core/keyed_flow_counter_table.sv
bench/testbench.sv
